// ===== rtl/pdm_pkg.sv =====
`timescale 1ns / 1ps
package pdm_pkg;

  // Width of the wrapping tick counter, which counts accepted samples.
  localparam int COUNTER_WIDTH = 16;

  localparam int TICK_RATE_W = 24;
  localparam int OUT_W       = 16;
  localparam int DUTY_W      = 7;

  localparam logic [TICK_RATE_W-1:0] TICK_RATE_RESET = 24'd1000000;
  localparam logic [DUTY_W-1:0]      DUTY_MAX        = 7'd100;
  localparam logic [OUT_W-1:0]       SAT_OUT         = 16'hFFFF;

  // The divider handles both the tick rate and high time times one hundred.
  localparam int DIV_W = (TICK_RATE_W > COUNTER_WIDTH + DUTY_W) ?
                         TICK_RATE_W : COUNTER_WIDTH + DUTY_W;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  typedef enum logic [5:0] {
    ST_WAIT_RISE1 = 6'b000001,
    ST_WAIT_RISE2 = 6'b000010,
    ST_WAIT_FALL  = 6'b000100,
    ST_DIV_FREQ   = 6'b001000,
    ST_DIV_DUTY   = 6'b010000,
    ST_EMIT       = 6'b100000
  } pdm_state_t;

  typedef struct packed {
    logic accept;
    logic zero_counter;
    logic capture_period;
    logic capture_high;
    logic start_freq;
    logic start_duty;
    logic load_out;
  } pdm_cmd_t;

  typedef struct packed {
    logic rise;
    logic fall;
    logic period_zero;
    logic div_busy;
    logic out_free;
  } pdm_stat_t;

endpackage

// ===== rtl/pdm_ctrl.sv =====
`timescale 1ns / 1ps
module pdm_ctrl
  import pdm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  pdm_stat_t stat,
  output logic      in_ready,
  output pdm_cmd_t  cmd
);

  pdm_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_WAIT_RISE1;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    logic acc;
    acc       = 1'b0;
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_WAIT_RISE1: begin
        in_ready = 1'b1;
        acc      = in_valid;
        if (acc && stat.rise) begin
          cmd.zero_counter = 1'b1;
          state_nxt        = ST_WAIT_RISE2;
        end
      end
      ST_WAIT_RISE2: begin
        in_ready = 1'b1;
        acc      = in_valid;
        if (acc && stat.rise) begin
          cmd.capture_period = 1'b1;
          state_nxt          = ST_WAIT_FALL;
        end
      end
      ST_WAIT_FALL: begin
        in_ready = 1'b1;
        acc      = in_valid;
        if (acc && stat.fall) begin
          cmd.capture_high = 1'b1;
          if (stat.period_zero) begin
            state_nxt = ST_EMIT;
          end else begin
            cmd.start_freq = 1'b1;
            state_nxt      = ST_DIV_FREQ;
          end
        end
      end
      ST_DIV_FREQ: begin
        if (!stat.div_busy) begin
          cmd.start_duty = 1'b1;
          state_nxt      = ST_DIV_DUTY;
        end
      end
      ST_DIV_DUTY: begin
        if (!stat.div_busy) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_WAIT_RISE1;
        end
      end
      default: begin
        state_nxt = ST_WAIT_RISE1;
      end
    endcase
    cmd.accept = acc;
  end

endmodule

// ===== rtl/pdm_datapath.sv =====
`timescale 1ns / 1ps
module pdm_datapath
  import pdm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   signal_level,
  input  logic                   cfg_wr_en,
  input  logic [TICK_RATE_W-1:0] cfg_wr_data,
  input  pdm_cmd_t               cmd,
  output pdm_stat_t              stat,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic [OUT_W-1:0]       out_period,
  output logic [OUT_W-1:0]       out_high,
  output logic [OUT_W-1:0]       out_freq,
  output logic [DUTY_W-1:0]      out_duty,
  output logic                   out_pzero
);

  localparam int SW = COUNTER_WIDTH + OUT_W;

  function automatic logic [OUT_W-1:0] sat_out(input logic [COUNTER_WIDTH-1:0] v);
    logic [SW-1:0] w;
    w = SW'(v);
    return (w > SW'(SAT_OUT)) ? SAT_OUT : w[OUT_W-1:0];
  endfunction

  logic [TICK_RATE_W-1:0]   tick_rate_r;
  logic [COUNTER_WIDTH-1:0] counter_r;
  logic                     prev_level_r;
  logic [COUNTER_WIDTH-1:0] period_r;
  logic [COUNTER_WIDTH-1:0] high_r;
  logic [COUNTER_WIDTH-1:0] counter_inc;

  logic [DIV_W-1:0]         dvd_r;
  logic [COUNTER_WIDTH-1:0] rem_r;
  logic [DIV_CNT_W-1:0]     div_cnt_r;
  logic [COUNTER_WIDTH:0]   rem_sh;
  logic [COUNTER_WIDTH:0]   rem_sub;
  logic                     rem_ge;
  logic [OUT_W-1:0]         freq_r;

  logic                     out_valid_r;
  logic [OUT_W-1:0]         out_period_r;
  logic [OUT_W-1:0]         out_high_r;
  logic [OUT_W-1:0]         out_freq_r;
  logic [DUTY_W-1:0]        out_duty_r;
  logic                     out_pzero_r;

  assign counter_inc = counter_r + 1'b1;

  assign stat.rise        = signal_level & ~prev_level_r;
  assign stat.fall        = ~signal_level & prev_level_r;
  assign stat.period_zero = (period_r == '0);
  assign stat.div_busy    = (div_cnt_r != '0);
  assign stat.out_free    = ~out_valid_r | out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_rate_r <= TICK_RATE_RESET;
    end else if (cfg_wr_en) begin
      tick_rate_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      counter_r    <= '0;
      prev_level_r <= 1'b0;
      period_r     <= '0;
    end else if (cmd.accept) begin
      counter_r    <= cmd.zero_counter ? '0 : counter_inc;
      prev_level_r <= signal_level;
      if (cmd.capture_period) begin
        period_r <= counter_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture_high) begin
      high_r <= counter_inc - period_r;
    end
  end

  // Restoring divider, one quotient bit per cycle, divisor is the period.
  assign rem_sh  = {rem_r, dvd_r[DIV_W-1]};
  assign rem_ge  = (rem_sh >= {1'b0, period_r});
  assign rem_sub = rem_sh - {1'b0, period_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
    end else if (cmd.start_freq || cmd.start_duty) begin
      div_cnt_r <= DIV_CNT_W'(DIV_W);
    end else if (div_cnt_r != '0) begin
      div_cnt_r <= div_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_freq) begin
      dvd_r <= DIV_W'(tick_rate_r);
      rem_r <= '0;
    end else if (cmd.start_duty) begin
      dvd_r <= DIV_W'(high_r) * DIV_W'(DUTY_MAX);
      rem_r <= '0;
    end else if (div_cnt_r != '0) begin
      dvd_r <= {dvd_r[DIV_W-2:0], rem_ge};
      rem_r <= rem_ge ? rem_sub[COUNTER_WIDTH-1:0] : rem_sh[COUNTER_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_duty) begin
      freq_r <= (dvd_r > DIV_W'(SAT_OUT)) ? SAT_OUT : dvd_r[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_period_r <= sat_out(period_r);
      out_high_r   <= sat_out(high_r);
      out_pzero_r  <= stat.period_zero;
      if (stat.period_zero) begin
        out_freq_r <= SAT_OUT;
        out_duty_r <= '0;
      end else begin
        out_freq_r <= freq_r;
        out_duty_r <= (dvd_r > DIV_W'(DUTY_MAX)) ? DUTY_MAX : dvd_r[DUTY_W-1:0];
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_period = out_period_r;
  assign out_high   = out_high_r;
  assign out_freq   = out_freq_r;
  assign out_duty   = out_duty_r;
  assign out_pzero  = out_pzero_r;

endmodule

// ===== rtl/pwm_period_duty_meter_core.sv =====
`timescale 1ns / 1ps
// PWM period and duty meter. Each input item is one sample of the measured
// signal, taken once per timer tick. The first rising edge zeroes a wrapping
// tick counter, the second rising edge captures the period and the next
// falling edge captures the high time; that falling edge then yields one
// result item holding the period, the high time, the frequency (tick rate
// over period, saturated at 65535) and the duty cycle in percent (clamped at
// 100). A zero period gives a frequency of 65535, a duty of 0 and the flag in
// out_tuser. While a measurement is running the block takes one item every
// cycle. After the item carrying the completing falling edge, in_tready stays
// low while both quotients come from one shared restoring divider that
// produces one quotient bit per cycle over a 24-bit dividend. It runs first
// for the frequency and then for the duty, each run ending in a hand-over to
// the next step, and then the output register is loaded (with no divider
// runs when the period is zero). If the output register still holds an
// earlier result that has not been taken, the stall lasts until it is. The
// result then waits in the output register, and the block keeps taking
// samples while it does.
module pwm_period_duty_meter_core
  import pdm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // Sample channel.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,    // [0] signal_level, rest zero
  // Result channel.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [55:0]            out_tdata,   // [15:0] period_ticks,
                                              // [31:16] high_ticks,
                                              // [47:32] frequency_hz,
                                              // [54:48] duty_percent, [55] zero
  output logic [0:0]             out_tuser,   // [0] period_zero
  // Tick rate register.
  input  logic                   cfg_wr_en,
  input  logic [TICK_RATE_W-1:0] cfg_wr_data
);

  pdm_cmd_t          cmd;
  pdm_stat_t         stat;
  logic [OUT_W-1:0]  period_w;
  logic [OUT_W-1:0]  high_w;
  logic [OUT_W-1:0]  freq_w;
  logic [DUTY_W-1:0] duty_w;
  logic              pzero_w;

  // The controller owns the capture phase and the sequencing of the divider.
  pdm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .stat     (stat),
    .in_ready (in_tready),
    .cmd      (cmd)
  );

  // The datapath holds the counter, the captures, the divider and the
  // output register.
  pdm_datapath u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .signal_level (in_tdata[0]),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .cmd          (cmd),
    .stat         (stat),
    .out_ready    (out_tready),
    .out_valid    (out_tvalid),
    .out_period   (period_w),
    .out_high     (high_w),
    .out_freq     (freq_w),
    .out_duty     (duty_w),
    .out_pzero    (pzero_w)
  );

  assign out_tdata = {1'b0, duty_w, freq_w, high_w, period_w};
  assign out_tuser = pzero_w;

endmodule

// ===== dv/tb_pwm_period_duty_meter_core.sv =====
`timescale 1ns / 1ps
// Each input item is one sample of the measured pulse signal. The bench builds
// the signal from pulse frames: a run of low samples, a first high run, a low
// gap, a second high run and one closing low sample. That frame takes the
// meter through its three phases and yields exactly one measurement. The
// directed rows below cover short frames, the tick rate extremes and the
// duty clamp. The random part then mixes frames of random length, level
// noise and new tick rates.
module tb_pwm_period_duty_meter_core;
  import pdm_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 4_000_000;
  // The divider still runs after the closing falling edge, so allow a
  // margin before touching the tick rate or ending the run.
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned HOLD_CYCLES = 3000;
  localparam int unsigned RANDOM_ITEMS = 500;
  localparam int unsigned RANDOM_RESULTS_MIN = 12;

  // One measurement, laid out as the fields of the result item.
  typedef struct packed {
    logic [OUT_W-1:0]  period;
    logic [OUT_W-1:0]  high;
    logic [OUT_W-1:0]  freq;
    logic [DUTY_W-1:0] duty;
    logic              pzero;
  } meter_result_t;

  // One directed frame. Lengths are in samples; the first high run plus the
  // gap gives the period, the second high run gives the high time.
  typedef struct packed {
    logic                   set_rate;
    logic [TICK_RATE_W-1:0] rate;
    logic [16:0]            lead_low;
    logic [16:0]            first_high;
    logic [16:0]            gap_low;
    logic [16:0]            second_high;
    logic                   typed;
    meter_result_t          want;
  } pulse_row_t;

  typedef enum logic [1:0] {
    PH_FIRST_RISE,
    PH_SECOND_RISE,
    PH_FALL
  } meter_phase_t;

  // Rows with typed results are read straight off the frame: the period is
  // first_high + gap_low (modulo 2^16) and the high time is second_high
  // (modulo 2^16). The remaining rows go through the predictor.
  localparam int N_ROWS = 10;
  localparam pulse_row_t PULSE_ROWS [N_ROWS] = '{
    // Shortest possible frame at the reset tick rate, frequency saturates.
    '{1'b0, 24'd0, 17'd0, 17'd1, 17'd1, 17'd1,
      1'b1, '{16'd2, 16'd1, 16'd65535, 7'd50, 1'b0}},
    // Unsaturated frequency at the reset tick rate.
    '{1'b0, 24'd0, 17'd3, 17'd60, 17'd40, 17'd30,
      1'b1, '{16'd100, 16'd30, 16'd10000, 7'd30, 1'b0}},
    // High time well beyond the period: duty clamped to one hundred.
    '{1'b0, 24'd0, 17'd1, 17'd1, 17'd1, 17'd5,
      1'b1, '{16'd2, 16'd5, 16'd65535, 7'd100, 1'b0}},
    // Tick rate of zero gives a frequency of zero.
    '{1'b1, 24'd0, 17'd2, 17'd2, 17'd2, 17'd1,
      1'b1, '{16'd4, 16'd1, 16'd0, 7'd25, 1'b0}},
    // Lowest legal tick rate.
    '{1'b1, 24'd1, 17'd1, 17'd1, 17'd1, 17'd1,
      1'b1, '{16'd2, 16'd1, 16'd0, 7'd50, 1'b0}},
    // Highest legal tick rate.
    '{1'b1, 24'd16000000, 17'd1, 17'd3, 17'd2, 17'd2,
      1'b1, '{16'd5, 16'd2, 16'd65535, 7'd40, 1'b0}},
    // Unsaturated frequency at the highest tick rate.
    '{1'b0, 24'd0, 17'd4, 17'd125, 17'd125, 17'd10,
      1'b1, '{16'd250, 16'd10, 16'd64000, 7'd4, 1'b0}},
    // All ones in the tick rate register.
    '{1'b1, 24'hFFFFFF, 17'd1, 17'd130, 17'd130, 17'd65,
      1'b1, '{16'd260, 16'd65, 16'd64527, 7'd25, 1'b0}},
    '{1'b1, 24'd1000000, 17'd5, 17'd7, 17'd13, 17'd4,
      1'b0, '0},
    '{1'b1, 24'd12345, 17'd0, 17'd40, 17'd57, 17'd33,
      1'b0, '0}
  };

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [7:0]             in_tdata = '0;     // [0] signal_level
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [55:0]            out_tdata;         // [15:0] period_ticks,
                                             // [31:16] high_ticks,
                                             // [47:32] frequency_hz,
                                             // [54:48] duty_percent
  logic [0:0]             out_tuser;         // [0] period_zero
  logic                   cfg_wr_en = 1'b0;
  logic [TICK_RATE_W-1:0] cfg_wr_data = '0;

  pwm_period_duty_meter_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state, as it stands after reset.
  logic [TICK_RATE_W-1:0]   tick_rate = TICK_RATE_RESET;
  meter_phase_t             meter_phase = PH_FIRST_RISE;
  logic [COUNTER_WIDTH-1:0] tick_count = '0;
  logic                     last_level = 1'b0;
  logic [COUNTER_WIDTH-1:0] held_period = '0;

  meter_result_t pending_results [$];
  // A directed row with a typed result hands it over here; the predictor
  // then queues that value instead of its own for the row's one measurement.
  logic          typed_pending = 1'b0;
  meter_result_t typed_result;

  int unsigned mismatches = 0;
  int unsigned results_made = 0;
  int unsigned cycle_count = 0;
  logic        calm = 1'b0;      // no idling on either side while set
  logic        hold_req = 1'b0;  // asks the receiver for its long hold-off

  function automatic logic [OUT_W-1:0] sat_out(logic [COUNTER_WIDTH-1:0] v);
    return (64'(v) > 64'(SAT_OUT)) ? SAT_OUT : 16'(v);
  endfunction

  // Advances the predicted meter by one sample and queues the measurement
  // that a completing falling edge produces.
  task automatic measure_sample(input logic lvl);
    logic                     rise;
    logic                     fall;
    logic [COUNTER_WIDTH-1:0] high;
    logic [63:0]              quotient;
    logic [63:0]              duty_wide;
    meter_result_t            res;
    rise = lvl & ~last_level;
    fall = ~lvl & last_level;
    // The counter advances first; edge actions see the advanced value.
    tick_count = tick_count + 1'b1;
    case (meter_phase)
      PH_FIRST_RISE: begin
        if (rise) begin
          tick_count = '0;
          meter_phase = PH_SECOND_RISE;
        end
      end
      PH_SECOND_RISE: begin
        if (rise) begin
          held_period = tick_count;
          meter_phase = PH_FALL;
        end
      end
      PH_FALL: begin
        if (fall) begin
          high = tick_count - held_period;
          res.period = sat_out(held_period);
          res.high = sat_out(high);
          if (held_period == '0) begin
            res.freq = SAT_OUT;
            res.duty = '0;
            res.pzero = 1'b1;
          end else begin
            // Both quotients use the full counter width, computed wide.
            quotient = 64'(tick_rate) / 64'(held_period);
            duty_wide = (64'(high) * 64'(DUTY_MAX)) / 64'(held_period);
            res.freq = (quotient > 64'(SAT_OUT)) ? SAT_OUT : quotient[15:0];
            res.duty = (duty_wide > 64'(DUTY_MAX)) ? DUTY_MAX : duty_wide[6:0];
            res.pzero = 1'b0;
          end
          if (typed_pending) begin
            pending_results.push_back(typed_result);
            typed_pending = 1'b0;
          end else begin
            pending_results.push_back(res);
          end
          results_made++;
          meter_phase = PH_FIRST_RISE;
        end
      end
      default: begin
        meter_phase = PH_FIRST_RISE;
      end
    endcase
    last_level = lvl;
  endtask

  // Offers one sample, with the occasional idle gap, and waits until the
  // meter takes it. in_tvalid stays high afterwards so that back-to-back
  // items need no second assignment within one step.
  task automatic send_sample(input logic lvl);
    if (!calm && $urandom_range(99) < 6) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {7'b0, lvl};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    measure_sample(lvl);
  endtask

  task automatic send_frame(input int unsigned lead_low, input int unsigned first_high,
                            input int unsigned gap_low, input int unsigned second_high);
    repeat (lead_low) send_sample(1'b0);
    repeat (first_high) send_sample(1'b1);
    repeat (gap_low) send_sample(1'b0);
    repeat (second_high) send_sample(1'b1);
    send_sample(1'b0);
  endtask

  // The tick rate is only written while the meter is idle: every queued
  // measurement has arrived and the divider has had time to finish.
  task automatic write_tick_rate(input logic [TICK_RATE_W-1:0] rate);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= rate;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tick_rate = rate;
  endtask

  // Mostly short runs so that many measurements complete, now and then a
  // long one.
  function automatic int unsigned pick_run();
    return ($urandom_range(99) < 95) ? $urandom_range(1, 10) : $urandom_range(11, 120);
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Result side: checks every accepted item against the oldest expectation,
  // then decides whether to be ready at the next edge. Once asked, it holds
  // off for a long stretch so that one result waits in the output register,
  // the next measurement finishes behind it and the input side stalls.
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;

  always @(posedge clk) begin
    meter_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result item, expected none, actual %h / %b",
                 $time, out_tdata, out_tuser);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("period_ticks", 32'(want.period), 32'(out_tdata[15:0]));
        check_field("high_ticks", 32'(want.high), 32'(out_tdata[31:16]));
        check_field("frequency_hz", 32'(want.freq), 32'(out_tdata[47:32]));
        check_field("duty_percent", 32'(want.duty), 32'(out_tdata[54:48]));
        check_field("period_zero", 32'(want.pzero), 32'(out_tuser[0]));
      end
    end
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(99) >= 6);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int unsigned rand_sent;
    int unsigned first_result;
    int unsigned pick;
    int unsigned n;
    int unsigned first_run;
    int unsigned gap_run;
    int unsigned second_run;
    logic [TICK_RATE_W-1:0] rate;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows. Each one starts in the first phase with the signal low
    // and ends on its closing low sample, so it yields exactly one result.
    for (int i = 0; i < N_ROWS; i++) begin
      if (PULSE_ROWS[i].set_rate) write_tick_rate(PULSE_ROWS[i].rate);
      if (PULSE_ROWS[i].typed) begin
        typed_result = PULSE_ROWS[i].want;
        typed_pending = 1'b1;
      end
      send_frame(32'(PULSE_ROWS[i].lead_low), 32'(PULSE_ROWS[i].first_high),
                 32'(PULSE_ROWS[i].gap_low), 32'(PULSE_ROWS[i].second_high));
    end

    // Random part: mostly well-formed frames with random lengths, some level
    // noise that leaves the meter in any phase, and a few new tick rates.
    rand_sent = 0;
    first_result = results_made;
    while (rand_sent < RANDOM_ITEMS || results_made - first_result < RANDOM_RESULTS_MIN) begin
      // A stretch with no idling at all on either side.
      calm <= (rand_sent >= 100 && rand_sent < 250);
      if (rand_sent >= 300) hold_req <= 1'b1;
      pick = $urandom_range(99);
      if (pick < 3) begin
        case ($urandom_range(3))
          0: rate = 24'd1;
          1: rate = 24'd16000000;
          default: rate = 24'($urandom_range(1, 16000000));
        endcase
        write_tick_rate(rate);
      end else if (pick < 20) begin
        n = $urandom_range(1, 16);
        repeat (n) send_sample(1'($urandom_range(1)));
        rand_sent += n;
      end else begin
        n = $urandom_range(0, 4);
        first_run = pick_run();
        gap_run = pick_run();
        second_run = pick_run();
        rand_sent += n + first_run + gap_run + second_run + 1;
        send_frame(n, first_run, gap_run, second_run);
      end
    end
    in_tvalid <= 1'b0;
    calm <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== pwm_period_duty_meter_core.f =====
rtl/pdm_pkg.sv
rtl/pdm_ctrl.sv
rtl/pdm_datapath.sv
rtl/pwm_period_duty_meter_core.sv
dv/tb_pwm_period_duty_meter_core.sv
